[hdl/cmos_region_checksum_check_defines.svh]
// assertion helpers used by the checksum checker core
`ifndef CMOS_REGION_CHECKSUM_CHECK_DEFINES_SVH
`define CMOS_REGION_CHECKSUM_CHECK_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/crs_pkg.sv]
package crs_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE_SUM = 2'd0,
        MODE_WORD_SUM = 2'd1,
        MODE_NEG_SUM  = 2'd2,
        MODE_CRC      = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // checksum length codes
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;

    localparam mode_t      MODE_RESET   = MODE_WORD_SUM;
    localparam logic [1:0] LENGTH_RESET = 2'd2;

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_TOP   = 16'h8000;
    localparam int          CRC_STEPS = 7;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] stored_checksum;
    } in_item_t;

    // xor in the byte, then seven shift steps
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        logic        out_bit;
        v = acc ^ {8'h00, b};
        for (int k = 0; k < CRC_STEPS; k++)
        begin
            out_bit = v[0];
            v = v >> 1;
            if (out_bit)
            begin
                v = (v | CRC_TOP) ^ CRC_POLY;
            end
        end
        return v;
    endfunction

endpackage

[hdl/cmos_region_checksum_check.sv]
// region checksum checker: takes one region byte per transfer on the slave stream,
// folds it into a 16-bit accumulator (byte sum, word sum, negated word sum or a
// crc-like seven-step shift with 0xa001) and, on the transfer marked by tlast, sends
// one result transfer with the computed checksum and a mismatch flag against the
// stored checksum carried by that same transfer. non-final bytes give no result.
// throughput is one byte per clock unless a final byte waits on the result register. a result
// passes the input register slice, then the result register. the accumulator clears after each
// final byte. the user must write mode and length through the config port only while the stream
// is idle; the block does not enforce it. reset selects word sum and a two-byte stored checksum
module cmos_region_checksum_check
    import crs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,
    // region bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] stored_checksum
    input  logic        s_axis_tlast,   // last_byte
    // check result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] checksum, [16] mismatch, rest zero
);

    mode_t       mode_reg;
    logic [1:0]  length_reg;
    in_item_t    in_item;
    in_item_t    item;
    logic        item_valid;
    logic        item_ready;
    logic [15:0] checksum;
    logic        mismatch;

    // config registers; the user writes them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_wdata);
                CFG_LENGTH: length_reg <= cfg_wdata;
                default:    length_reg <= length_reg;
            endcase
        end
    end

    assign in_item.data_byte       = s_axis_tdata[7:0];
    assign in_item.last_byte       = s_axis_tlast;
    assign in_item.stored_checksum = s_axis_tdata[23:8];

    // input register slice
    crs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // accumulator, finalize and compare, result register
    crs_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode_reg),
        .checksum_length (length_reg),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .checksum        (checksum),
        .mismatch        (mismatch)
    );

    assign m_axis_tdata = {7'b0000000, mismatch, checksum};

endmodule

[hdl/crs_in_stage.sv]
module crs_in_stage
    import crs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    input  logic     item_ready,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // register slice: refill in the same cycle the held item moves on
    assign in_ready   = !valid_reg || item_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/crs_core.sv]
`include "cmos_region_checksum_check_defines.svh"

module crs_core
    import crs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mode_t       mode,
    input  logic [1:0]  checksum_length,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] checksum,
    output logic        mismatch
);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [15:0] folded;
    logic [15:0] result;
    logic [15:0] expect_val;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] checksum_reg;
    logic        mismatch_reg;
    logic        out_free;
    logic        consume;
    logic        finish;

    // only a final byte needs room in the result register
    assign out_free   = !out_valid_reg || out_ready;
    assign item_ready = !item.last_byte || out_free;
    assign consume    = item_valid && item_ready;
    assign finish     = consume && item.last_byte;

    always_comb
    begin
        if (mode == MODE_CRC)
        begin
            folded = crc_fold(acc_reg, item.data_byte);
        end
        else
        begin
            folded = acc_reg + {8'h00, item.data_byte};
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_BYTE_SUM: result = {8'h00, folded[7:0]};
            MODE_NEG_SUM:  result = (~folded) + 16'd1;
            MODE_WORD_SUM: result = folded;
            MODE_CRC:      result = folded;
            default:       result = folded;
        endcase
    end

    always_comb
    begin
        priority if (checksum_length == LEN_NONE)
        begin
            expect_val = 16'h0000;
        end
        else if (checksum_length == LEN_ONE)
        begin
            expect_val = {8'h00, item.stored_checksum[7:0]};
        end
        else
        begin
            expect_val = item.stored_checksum;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (consume)
        begin
            acc_next = item.last_byte ? 16'h0000 : folded;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            checksum_reg <= result;
            mismatch_reg <= (expect_val != result);
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;
    assign mismatch  = mismatch_reg;

    `CRS_ASSERT_NEXT(acc_clear_after_last, finish, acc_reg == 16'h0000, "accumulator not cleared after final byte")
    `CRS_ASSERT_NOW(result_from_last, $rose(out_valid_reg), $past(finish), "result appeared without a final byte")
    `CRS_ASSERT_NEXT(byte_mode_high_zero, finish && (mode == MODE_BYTE_SUM), checksum_reg[15:8] == 8'h00, "byte sum result not zero-extended")

endmodule

[bench/cmos_region_checksum_check_tb.sv]
module cmos_region_checksum_check_tb;
    import crs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits and timing
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;      // extra wait after the last result has arrived
    localparam int HOLD_CYCLES  = 300;    // long output stall in the pressure test
    localparam int PRINT_CAP    = 40;

    // stored-length codes the package does not name
    localparam logic [1:0] LEN_TWO = 2'd2;
    localparam logic [1:0] LEN_SAT = 2'd3;

    typedef struct {
        logic [15:0] checksum;
        logic        mismatch;
    } region_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [1:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [7:0] data_byte, [23:8] stored_checksum
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [15:0] checksum, [16] mismatch

    // shadow of the block: accumulator and the two registers
    logic [15:0] region_acc;
    mode_t       sum_mode;
    logic [1:0]  stored_len;

    // results still owed by the block, oldest first
    region_result_t pending_sums[$];

    int  error_count;
    int  bytes_sent;
    int  regions_checked;
    int  regions_flagged;
    int  cycle_count;

    // idling controls read by the sender task and the receiver process
    bit  source_idling;
    bit  sink_idling;
    bit  hold_request;

    cmos_region_checksum_check i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_sums.size());
            $display("FAIL cmos_region_checksum_check");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // crc-like fold: xor in the byte, then seven right shifts, each one
    // that drops a set bit puts it back on top and applies the polynomial
    function automatic logic [15:0] crc_shift_fold(input logic [15:0] acc,
                                                   input logic [7:0]  b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        for (int k = 0; k < CRC_STEPS; k++)
        begin
            if (v[0])
                v = {1'b1, v[15:1]} ^ CRC_POLY;
            else
                v = {1'b0, v[15:1]};
        end
        return v;
    endfunction

    // one byte into the accumulator under the mode current at that byte
    function automatic logic [15:0] fold_byte(input logic [15:0] acc, input mode_t m,
                                              input logic [7:0] b);
        if (m == MODE_CRC)
            return crc_shift_fold(acc, b);
        return acc + {8'h00, b};
    endfunction

    // output form follows the mode at the final byte
    function automatic logic [15:0] final_checksum(input logic [15:0] acc, input mode_t m);
        case (m)
            MODE_BYTE_SUM: return {8'h00, acc[7:0]};
            MODE_NEG_SUM:  return ~acc + 16'd1;
            default:       return acc;
        endcase
    endfunction

    // stored value as the compare sees it; length three saturates to two
    function automatic logic [15:0] stored_view(input logic [15:0] stored,
                                                input logic [1:0]  len);
        if (len == LEN_NONE)
            return 16'h0000;
        if (len == LEN_ONE)
            return {8'h00, stored[7:0]};
        return stored;
    endfunction

    // checksum the block would report if b closed the region now
    function automatic logic [15:0] closing_checksum(input logic [7:0] b);
        return final_checksum(fold_byte(region_acc, sum_mode, b), sum_mode);
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // every result transfer is matched against the oldest expectation
    always @(posedge clk)
    begin : result_check
        region_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected",
                                m_axis_tdata[15:0], 16'h0000);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (m_axis_tdata[15:0] !== want.checksum)
                    report_mismatch("checksum", m_axis_tdata[15:0], want.checksum);
                if (m_axis_tdata[16] !== want.mismatch)
                    report_mismatch("mismatch flag", {15'd0, m_axis_tdata[16]},
                                    {15'd0, want.mismatch});
                regions_checked++;
                if (want.mismatch)
                    regions_flagged++;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random not-ready bursts while sink_idling, or one long hold when asked
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int burst;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long stall so the block backs up and drops s_axis_tready
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (sink_idling && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one region byte, wait for the transfer, then update the shadow;
    // valid stays high on return so back-to-back bytes have no gap
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [15:0] stored);
        int             gap;
        region_result_t r;
        if (source_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stored, b};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);

        // transfer taken at this edge
        bytes_sent++;
        region_acc = fold_byte(region_acc, sum_mode, b);
        if (last)
        begin
            r.checksum = final_checksum(region_acc, sum_mode);
            r.mismatch = (stored_view(stored, stored_len) != r.checksum);
            pending_sums.push_back(r);
            region_acc = 16'h0000;
        end
    endtask

    // stop offering, let every result arrive and the pipeline empty
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write; callers drain first so the block is idle
    task automatic write_reg(input logic addr, input logic [1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_MODE)
            sum_mode = mode_t'(value);
        else
            stored_len = value;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values: word sum, two-byte stored checksum
    task automatic test_reset_defaults();
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'h00, 1'b1, 16'h00FF);
        send_byte(8'hFF, 1'b1, 16'h0000);
        drain_block();
    endtask

    // extremes of the byte in byte sum, negated sum and crc modes, matching and not
    task automatic test_each_mode();
        write_reg(CFG_MODE, MODE_BYTE_SUM);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b1, 16'h00FE);          // sum wraps past 8 bits
        drain_block();
        write_reg(CFG_MODE, MODE_NEG_SUM);
        send_byte(8'h01, 1'b1, 16'hFFFF);
        send_byte(8'h00, 1'b1, 16'h0000);          // negating zero stays zero
        drain_block();
        write_reg(CFG_MODE, MODE_CRC);
        send_byte(8'hFF, 1'b1, 16'hABCD);
        send_byte(8'h80, 1'b1, closing_checksum(8'h80));
        drain_block();
    endtask

    // stored lengths 1, 0 and the saturating 3, then back to 2
    task automatic test_stored_lengths();
        write_reg(CFG_MODE, MODE_WORD_SUM);
        write_reg(CFG_LENGTH, LEN_ONE);
        send_byte(8'h12, 1'b1, 16'hFF12);          // only the low byte counts
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b1, 16'h01FE);          // low byte vs full 16-bit sum
        drain_block();
        write_reg(CFG_LENGTH, LEN_NONE);
        send_byte(8'h00, 1'b1, 16'hFFFF);          // stored taken as zero
        send_byte(8'h05, 1'b1, 16'h0005);
        drain_block();
        write_reg(CFG_LENGTH, LEN_SAT);
        send_byte(8'h34, 1'b1, 16'h0034);
        drain_block();
        write_reg(CFG_LENGTH, LEN_TWO);
    endtask

    // each byte folds by the mode at its own transfer
    task automatic test_mode_switch_mid_region();
        write_reg(CFG_MODE, MODE_WORD_SUM);
        send_byte(8'h10, 1'b0, 16'h0000);
        send_byte(8'h20, 1'b0, 16'h0000);
        drain_block();
        write_reg(CFG_MODE, MODE_CRC);
        send_byte(8'h30, 1'b1, closing_checksum(8'h30));
        drain_block();
    endtask

    // random regions, mostly short, with random register settings between
    // regions and an occasional mode switch inside one
    task automatic test_random_regions(input int target_bytes);
        int          sent;
        int          len;
        logic [7:0]  b;
        logic [15:0] peek;
        logic [15:0] stored;
        sent = 0;
        while (sent < target_bytes)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                drain_block();
                write_reg(CFG_MODE, 2'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain_block();
                write_reg(CFG_LENGTH, 2'($urandom_range(0, 3)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                if (i < len - 1)
                begin
                    if (i == 1 && $urandom_range(0, 11) == 0)
                    begin
                        drain_block();
                        write_reg(CFG_MODE, 2'($urandom_range(0, 3)));
                    end
                    send_byte(b, 1'b0, 16'($urandom));
                end
                else
                begin
                    // two of the four choices carry the expected checksum (its low byte under length one)
                    peek = closing_checksum(b);
                    case ($urandom_range(0, 3))
                        0:       stored = peek;
                        1:       stored = (stored_len == LEN_ONE) ?
                                          {8'($urandom), peek[7:0]} : peek;
                        2:       stored = 16'($urandom);
                        default: stored = peek ^ (16'h0001 << $urandom_range(0, 15));
                    endcase
                    send_byte(b, 1'b1, stored);
                end
            end
            sent += len;
        end
        drain_block();
    endtask

    // receiver holds off while the sender keeps offering one-byte regions,
    // then the sender pauses until every result is back
    task automatic test_output_stall(input int count);
        logic [7:0] b;
        source_idling = 1'b0;
        hold_request  = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom);
            send_byte(b, 1'b1, ($urandom_range(0, 1) != 0) ? closing_checksum(b)
                                                            : 16'($urandom));
        end
        drain_block();
        wait (hold_request == 1'b0);
        source_idling = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_MODE;
        cfg_wdata     = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tlast  = 1'b0;
        region_acc    = 16'h0000;
        sum_mode      = MODE_RESET;
        stored_len    = LENGTH_RESET;
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        hold_request  = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_each_mode();
        test_stored_lengths();
        test_mode_switch_mid_region();
        test_random_regions(420);
        test_output_stall(40);

        // last stretch at full rate on both sides
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        test_random_regions(60);

        $display("checked %0d regions from %0d bytes, %0d of them flagged as mismatching",
                 regions_checked, bytes_sent, regions_flagged);
        $display("%s, a mid-region mode switch and a %0d-cycle output stall",
                 "all four modes and stored lengths 0 to 3", HOLD_CYCLES);
        if (error_count == 0)
            $display("PASS cmos_region_checksum_check");
        else
            $display("FAIL cmos_region_checksum_check");
        $finish;
    end

endmodule
